// ===== src/dhcp_rfe_pkg.sv =====
package dhcp_rfe_pkg;

  // Default for the payload length limit
  localparam int MAX_PAYLOAD_DEF = 512;

  // Expected transaction id after reset
  localparam logic [31:0] XID_RESET = 32'h5049_5801;

  // Byte offsets in the payload
  localparam int OFS_OP          = 0;
  localparam int OFS_XID_FIRST   = 4;
  localparam int OFS_XID_LAST    = 7;
  localparam int OFS_ADDR_FIRST  = 16;
  localparam int OFS_ADDR_LAST   = 19;
  localparam int OFS_COOKIE0     = 236;
  localparam int OFS_COOKIE1     = 237;
  localparam int OFS_OPTIONS     = 240;

  // Lengths that make a field valid
  localparam int LEN_HEADER      = 244;
  localparam int LEN_COOKIE      = 238;
  localparam int LEN_ADDR        = 20;

  // Byte values
  localparam logic [7:0]  BOOTREPLY     = 8'd2;
  localparam logic [7:0]  COOKIE_B0     = 8'h63;
  localparam logic [7:0]  COOKIE_B1     = 8'h82;
  localparam logic [7:0]  OPT_PAD       = 8'd0;
  localparam logic [7:0]  OPT_END       = 8'd255;
  localparam logic [7:0]  OPT_MASK      = 8'd1;
  localparam logic [7:0]  OPT_ROUTER    = 8'd3;
  localparam logic [7:0]  OPT_DNS       = 8'd6;
  localparam logic [7:0]  OPT_MSG_TYPE  = 8'd53;
  localparam logic [7:0]  OPT_SRV_IDENT = 8'd54;
  localparam logic [15:0] SERVER_PORT   = 16'd67;

  // Option walk phase
  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE,
    PH_DONE
  } opt_phase_t;

  // Option slots we keep
  localparam int SLOT_COUNT = 5;
  typedef enum logic [2:0] {
    SLOT_MSG,
    SLOT_SERVER,
    SLOT_MASK,
    SLOT_ROUTER,
    SLOT_DNS,
    SLOT_NONE
  } slot_t;

  // One result word
  typedef struct packed {
    logic        header_ok;
    logic        cookie_ok;
    logic        msg_type_found;
    logic [7:0]  msg_type;
    logic [31:0] offer_addr;
    logic        srv_ident_found;
    logic [31:0] srv_ident;
    logic [31:0] netmask;
    logic [31:0] gateway;
    logic [31:0] dns_server;
  } result_t;

  // Option type to slot
  function automatic slot_t slot_of(logic [7:0] opt_type);
    slot_t s;
    case (opt_type)
      OPT_MSG_TYPE:  s = SLOT_MSG;
      OPT_SRV_IDENT: s = SLOT_SERVER;
      OPT_MASK:      s = SLOT_MASK;
      OPT_ROUTER:    s = SLOT_ROUTER;
      OPT_DNS:       s = SLOT_DNS;
      default:       s = SLOT_NONE;
    endcase
    return s;
  endfunction

  // Length rule per slot
  function automatic logic len_good(slot_t s, logic [7:0] len);
    logic ok;
    case (s)
      SLOT_MSG:    ok = (len == 8'd1);
      SLOT_SERVER: ok = (len == 8'd4);
      SLOT_MASK:   ok = (len == 8'd4);
      SLOT_ROUTER: ok = (len >= 8'd4);
      SLOT_DNS:    ok = (len >= 8'd4);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// ===== src/dhcp_reply_field_extractor.sv =====
// DHCP reply field extractor. Feed the UDP payload of a reply one byte per
// word on the in_ channel, with in_last_byte set on the final byte and
// in_src_port valid on that word; exactly one result word follows each
// last byte on the out_ channel. Bytes stream at one per cycle while
// in_ready is high: an accepted byte sits in an input register while the
// header checks and the option walk update, and the result of a last byte
// then moves into the output register, which drives out_valid. in_ready
// only drops while a finished result is held by out_ready and another last
// byte is waiting behind it. Bytes past MAX_PAYLOAD are ignored. Fields
// whose bytes or options are absent read as zero; header_ok and cookie_ok
// say whether to trust the rest. Write cfg_wr_data with cfg_wr_en while
// no packet is in flight to set the expected transaction id (reset value
// 0x50495801).
module dhcp_reply_field_extractor #(
  parameter int MAX_PAYLOAD = dhcp_rfe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [15:0] in_src_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_header_ok,
  output logic        out_cookie_ok,
  output logic        out_msg_type_found,
  output logic [7:0]  out_msg_type,
  output logic [31:0] out_offer_addr,
  output logic        out_srv_ident_found,
  output logic [31:0] out_srv_ident,
  output logic [31:0] out_netmask,
  output logic [31:0] out_gateway,
  output logic [31:0] out_dns_server,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import dhcp_rfe_pkg::*;

  logic [31:0] xid_r;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [15:0] s1_port_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r;
  result_t     res;
  logic        out_free;
  logic        s1_adv;
  logic        load;
  logic        in_acc;

  // Stage handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign load     = s1_adv && s1_last_r;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  // Transaction id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xid_r <= XID_RESET;
    end else if (cfg_wr_en) begin
      xid_r <= cfg_wr_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_port_r <= in_src_port;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  dhcp_rfe_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_adv),
    .data_byte  (s1_byte_r),
    .last_byte  (s1_last_r),
    .src_port   (s1_port_r),
    .xid        (xid_r),
    .res        (res)
  );

  assign out_valid           = out_valid_r;
  assign out_header_ok       = out_res_r.header_ok;
  assign out_cookie_ok       = out_res_r.cookie_ok;
  assign out_msg_type_found  = out_res_r.msg_type_found;
  assign out_msg_type        = out_res_r.msg_type;
  assign out_offer_addr      = out_res_r.offer_addr;
  assign out_srv_ident_found = out_res_r.srv_ident_found;
  assign out_srv_ident       = out_res_r.srv_ident;
  assign out_netmask         = out_res_r.netmask;
  assign out_gateway         = out_res_r.gateway;
  assign out_dns_server      = out_res_r.dns_server;

`ifndef SYNTHESIS
  // a new result never lands on one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  // a held last byte stays until the result register frees
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r && !out_free) |=> (s1_valid_r && s1_last_r))
    else $error("last byte dropped while result pending");

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!s1_valid_r && !out_valid_r))
    else $error("stages not empty after reset");
`endif

endmodule

// ===== src/dhcp_rfe_parser.sv =====
module dhcp_rfe_parser #(
  parameter int MAX_PAYLOAD = dhcp_rfe_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  input  logic [15:0]           src_port,
  input  logic [31:0]           xid,
  output dhcp_rfe_pkg::result_t res
);
  import dhcp_rfe_pkg::*;

  localparam int OFS_W = $clog2(MAX_PAYLOAD + 1);

  logic [OFS_W-1:0] offset_r, offset_nxt;
  logic             op_ok_r, op_ok_nxt;
  logic             xid_ok_r, xid_ok_nxt;
  logic             cookie_ok_r, cookie_ok_nxt;
  logic [31:0]      addr_r, addr_nxt;
  opt_phase_t       phase_r, phase_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [31:0]      cap_r, cap_nxt;
  logic [SLOT_COUNT-1:0] found_r, found_nxt;
  logic [SLOT_COUNT-1:0] good_r, good_nxt;
  logic [31:0]      val_r [SLOT_COUNT];
  logic [31:0]      val_nxt [SLOT_COUNT];

  logic             take;
  logic [7:0]       want;
  logic             rec;
  logic [7:0]       rec_len;
  logic [31:0]      rec_val;
  logic [7:0]       opt_pos;
  slot_t            slot;

  // Per-byte header checks and option walk
  always_comb begin
    offset_nxt    = offset_r;
    op_ok_nxt     = op_ok_r;
    xid_ok_nxt    = xid_ok_r;
    cookie_ok_nxt = cookie_ok_r;
    addr_nxt      = addr_r;
    phase_nxt     = phase_r;
    type_nxt      = type_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    cap_nxt       = cap_r;
    found_nxt     = found_r;
    good_nxt      = good_r;
    val_nxt       = val_r;
    rec           = 1'b0;
    rec_len       = len_r;
    rec_val       = cap_r;
    opt_pos       = len_r - rem_r;
    slot          = slot_of(type_r);
    take          = (offset_r < OFS_W'(MAX_PAYLOAD));

    // xid byte expected at this offset, big-endian
    case (offset_r[1:0])
      2'd0:    want = xid[31:24];
      2'd1:    want = xid[23:16];
      2'd2:    want = xid[15:8];
      default: want = xid[7:0];
    endcase

    if (take) begin
      offset_nxt = offset_r + 1'b1;
      if (offset_r == OFS_W'(OFS_OP) && data_byte != BOOTREPLY) begin
        op_ok_nxt = 1'b0;
      end
      if (offset_r >= OFS_W'(OFS_XID_FIRST) && offset_r <= OFS_W'(OFS_XID_LAST) &&
          data_byte != want) begin
        xid_ok_nxt = 1'b0;
      end
      if (offset_r >= OFS_W'(OFS_ADDR_FIRST) && offset_r <= OFS_W'(OFS_ADDR_LAST)) begin
        addr_nxt = {addr_r[23:0], data_byte};
      end
      if ((offset_r == OFS_W'(OFS_COOKIE0) && data_byte != COOKIE_B0) ||
          (offset_r == OFS_W'(OFS_COOKIE1) && data_byte != COOKIE_B1)) begin
        cookie_ok_nxt = 1'b0;
      end

      if (offset_r >= OFS_W'(OFS_OPTIONS)) begin
        case (phase_r)
          PH_TYPE: begin
            if (data_byte == OPT_END) begin
              phase_nxt = PH_DONE;
            end else if (data_byte != OPT_PAD) begin
              type_nxt  = data_byte;
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            len_nxt = data_byte;
            rem_nxt = data_byte;
            cap_nxt = '0;
            if (data_byte == 8'd0) begin
              rec       = 1'b1;
              rec_len   = 8'd0;
              rec_val   = '0;
              phase_nxt = PH_TYPE;
            end else begin
              phase_nxt = PH_VALUE;
            end
          end
          PH_VALUE: begin
            // keep only the first four value bytes
            if (opt_pos < 8'd4) begin
              cap_nxt = {cap_r[23:0], data_byte};
            end
            rem_nxt = rem_r - 1'b1;
            if (rem_r == 8'd1) begin
              rec       = 1'b1;
              rec_val   = cap_nxt;
              phase_nxt = PH_TYPE;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // first complete instance of each option wins
    if (rec && slot != SLOT_NONE && !found_r[slot]) begin
      found_nxt[slot] = 1'b1;
      good_nxt[slot]  = len_good(slot, rec_len);
      val_nxt[slot]   = rec_val;
    end
  end

  // Result from the state after this byte
  always_comb begin
    res.header_ok       = (offset_nxt >= OFS_W'(LEN_HEADER)) &&
                          (src_port == SERVER_PORT) && op_ok_nxt && xid_ok_nxt;
    res.cookie_ok       = (offset_nxt >= OFS_W'(LEN_COOKIE)) && cookie_ok_nxt;
    res.msg_type_found  = good_nxt[SLOT_MSG];
    res.msg_type        = good_nxt[SLOT_MSG] ? val_nxt[SLOT_MSG][7:0] : 8'd0;
    res.offer_addr      = (offset_nxt >= OFS_W'(LEN_ADDR)) ? addr_nxt : 32'd0;
    res.srv_ident_found = good_nxt[SLOT_SERVER];
    res.srv_ident       = good_nxt[SLOT_SERVER] ? val_nxt[SLOT_SERVER] : 32'd0;
    res.netmask         = good_nxt[SLOT_MASK]   ? val_nxt[SLOT_MASK]   : 32'd0;
    res.gateway         = good_nxt[SLOT_ROUTER] ? val_nxt[SLOT_ROUTER] : 32'd0;
    res.dns_server      = good_nxt[SLOT_DNS]    ? val_nxt[SLOT_DNS]    : 32'd0;
  end

  // Control state, cleared at reset and after each last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      op_ok_r     <= 1'b1;
      xid_ok_r    <= 1'b1;
      cookie_ok_r <= 1'b1;
      phase_r     <= PH_TYPE;
      found_r     <= '0;
      good_r      <= '0;
    end else if (en) begin
      if (last_byte) begin
        offset_r    <= '0;
        op_ok_r     <= 1'b1;
        xid_ok_r    <= 1'b1;
        cookie_ok_r <= 1'b1;
        phase_r     <= PH_TYPE;
        found_r     <= '0;
        good_r      <= '0;
      end else begin
        offset_r    <= offset_nxt;
        op_ok_r     <= op_ok_nxt;
        xid_ok_r    <= xid_ok_nxt;
        cookie_ok_r <= cookie_ok_nxt;
        phase_r     <= phase_nxt;
        found_r     <= found_nxt;
        good_r      <= good_nxt;
      end
    end
  end

  // Data state; every field is rewritten before it is read again
  always_ff @(posedge clk) begin
    if (en) begin
      addr_r <= addr_nxt;
      type_r <= type_nxt;
      rem_r  <= rem_nxt;
      len_r  <= len_nxt;
      cap_r  <= cap_nxt;
      val_r  <= val_nxt;
    end
  end

`ifndef SYNTHESIS
  // walk only leaves the type phase once options have started
  a_phase_in_options: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_TYPE) |-> (offset_r > OFS_W'(OFS_OPTIONS)))
    else $error("option phase advanced before option area");

  // value phase always has bytes left to take
  a_value_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_VALUE) |-> (rem_r != 8'd0))
    else $error("value phase with zero remaining length");

  // byte counter stops at the payload limit
  a_offset_cap: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= OFS_W'(MAX_PAYLOAD))
    else $error("byte offset past payload limit");
`endif

endmodule

// ===== verif/dhcp_reply_field_extractor_test.sv =====
module dhcp_reply_field_extractor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dhcp_rfe_pkg::*;

  localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD = 200;

  // one input word
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] port;
  } byte_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [15:0] in_src_port = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_header_ok;
  logic        out_cookie_ok;
  logic        out_msg_type_found;
  logic [7:0]  out_msg_type;
  logic [31:0] out_offer_addr;
  logic        out_srv_ident_found;
  logic [31:0] out_srv_ident;
  logic [31:0] out_netmask;
  logic [31:0] out_gateway;
  logic [31:0] out_dns_server;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // stimulus and scoreboard state
  byte_word_t  pending_words[$];
  result_t     expected_replies[$];
  logic [7:0]  pkt[$];
  int unsigned mismatches = 0;
  logic        sender_idles = 1'b1;
  logic        receiver_idles = 1'b1;
  logic        hold_go = 1'b0;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_count = 0;

  // reply parser mirror
  logic [31:0] xid_reg = XID_RESET;
  int unsigned rx_count;
  logic        op_good, xid_good, cookie_good;
  logic [31:0] addr_acc;
  opt_phase_t  walk;
  logic [7:0]  cur_type, cur_len, cur_left;
  logic [31:0] cur_value;
  logic        seen [SLOT_COUNT];
  logic [7:0]  seen_len [SLOT_COUNT];
  logic [31:0] seen_val [SLOT_COUNT];

  dhcp_reply_field_extractor #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .in_src_port        (in_src_port),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_header_ok      (out_header_ok),
    .out_cookie_ok      (out_cookie_ok),
    .out_msg_type_found (out_msg_type_found),
    .out_msg_type       (out_msg_type),
    .out_offer_addr     (out_offer_addr),
    .out_srv_ident_found(out_srv_ident_found),
    .out_srv_ident      (out_srv_ident),
    .out_netmask        (out_netmask),
    .out_gateway        (out_gateway),
    .out_dns_server     (out_dns_server),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // back to the start-of-packet state
  task automatic reset_packet();
    rx_count = 0;
    op_good = 1'b1;
    xid_good = 1'b1;
    cookie_good = 1'b1;
    addr_acc = '0;
    walk = PH_TYPE;
    cur_type = '0;
    cur_len = '0;
    cur_left = '0;
    cur_value = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      seen[i] = 1'b0;
      seen_len[i] = '0;
      seen_val[i] = '0;
    end
  endtask

  // first complete instance of an option we care about wins
  task automatic keep_option();
    slot_t s;
    case (cur_type)
      OPT_MSG_TYPE:  s = SLOT_MSG;
      OPT_SRV_IDENT: s = SLOT_SERVER;
      OPT_MASK:      s = SLOT_MASK;
      OPT_ROUTER:    s = SLOT_ROUTER;
      OPT_DNS:       s = SLOT_DNS;
      default:       s = SLOT_NONE;
    endcase
    if (s != SLOT_NONE && !seen[s]) begin
      seen[s] = 1'b1;
      seen_len[s] = cur_len;
      seen_val[s] = cur_value;
    end
  endtask

  // advance the mirror by one accepted byte; queue a reply on the last one
  task automatic parse_reply_byte(byte_word_t w);
    int idx;
    result_t r;
    if (rx_count < PAYLOAD_LIMIT) begin
      idx = rx_count;
      if (idx == OFS_OP && w.data != BOOTREPLY) op_good = 1'b0;
      if (idx >= OFS_XID_FIRST && idx <= OFS_XID_LAST &&
          w.data != xid_reg[8*(OFS_XID_LAST - idx) +: 8]) xid_good = 1'b0;
      if (idx >= OFS_ADDR_FIRST && idx <= OFS_ADDR_LAST) addr_acc = {addr_acc[23:0], w.data};
      if ((idx == OFS_COOKIE0 && w.data != COOKIE_B0) ||
          (idx == OFS_COOKIE1 && w.data != COOKIE_B1)) cookie_good = 1'b0;
      if (idx >= OFS_OPTIONS) begin
        case (walk)
          PH_TYPE: begin
            if (w.data == OPT_END) begin
              walk = PH_DONE;
            end else if (w.data != OPT_PAD) begin
              cur_type = w.data;
              walk = PH_LEN;
            end
          end
          PH_LEN: begin
            cur_len = w.data;
            cur_left = w.data;
            cur_value = '0;
            if (w.data == 8'd0) begin
              keep_option();
              walk = PH_TYPE;
            end else begin
              walk = PH_VALUE;
            end
          end
          PH_VALUE: begin
            // only the first four value bytes are kept
            if (8'(cur_len - cur_left) < 8'd4) cur_value = {cur_value[23:0], w.data};
            cur_left = cur_left - 8'd1;
            if (cur_left == 8'd0) begin
              keep_option();
              walk = PH_TYPE;
            end
          end
          default: ;
        endcase
      end
      rx_count++;
    end
    if (w.last) begin
      r = '0;
      r.header_ok = (rx_count >= LEN_HEADER) && (w.port == SERVER_PORT) && op_good && xid_good;
      r.cookie_ok = (rx_count >= LEN_COOKIE) && cookie_good;
      r.msg_type_found = seen[SLOT_MSG] && seen_len[SLOT_MSG] == 8'd1;
      if (r.msg_type_found) r.msg_type = seen_val[SLOT_MSG][7:0];
      if (rx_count >= LEN_ADDR) r.offer_addr = addr_acc;
      r.srv_ident_found = seen[SLOT_SERVER] && seen_len[SLOT_SERVER] == 8'd4;
      if (r.srv_ident_found) r.srv_ident = seen_val[SLOT_SERVER];
      if (seen[SLOT_MASK] && seen_len[SLOT_MASK] == 8'd4) r.netmask = seen_val[SLOT_MASK];
      if (seen[SLOT_ROUTER] && seen_len[SLOT_ROUTER] >= 8'd4) r.gateway = seen_val[SLOT_ROUTER];
      if (seen[SLOT_DNS] && seen_len[SLOT_DNS] >= 8'd4) r.dns_server = seen_val[SLOT_DNS];
      expected_replies.push_back(r);
      reset_packet();
    end
  endtask

  // byte driver
  always @(posedge clk) begin : byte_driver
    byte_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
      reset_packet();
      expected_replies.delete();
    end else begin
      if (in_valid && in_ready) parse_reply_byte({in_data_byte, in_last_byte, in_src_port});
      if (!in_valid || in_ready) begin
        if (tx_wait != 0) begin
          tx_wait <= tx_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          w = pending_words.pop_front();
          in_data_byte <= w.data;
          in_last_byte <= w.last;
          in_src_port <= w.port;
          in_valid <= 1'b1;
          tx_wait <= sender_idles ? $urandom_range(0, 3) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_reply();
    result_t want;
    if (expected_replies.size() == 0) begin
      $display("%0t: result word with nothing expected, got header_ok %b offer_addr %h",
               $time, out_header_ok, out_offer_addr);
      mismatches++;
      return;
    end
    want = expected_replies.pop_front();
    check_field("header_ok", 32'(want.header_ok), 32'(out_header_ok));
    check_field("cookie_ok", 32'(want.cookie_ok), 32'(out_cookie_ok));
    check_field("msg_type_found", 32'(want.msg_type_found), 32'(out_msg_type_found));
    check_field("msg_type", 32'(want.msg_type), 32'(out_msg_type));
    check_field("offer_addr", want.offer_addr, out_offer_addr);
    check_field("srv_ident_found", 32'(want.srv_ident_found), 32'(out_srv_ident_found));
    check_field("srv_ident", want.srv_ident, out_srv_ident);
    check_field("netmask", want.netmask, out_netmask);
    check_field("gateway", want.gateway, out_gateway);
    check_field("dns_server", want.dns_server, out_dns_server);
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin : reply_monitor
    int unsigned gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      hold_count <= 0;
    end else begin
      if (out_valid && out_ready) compare_reply();
      if (hold_go && hold_count < LONG_HOLD) begin
        // long hold-off so the block backs up
        hold_count <= hold_count + 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready && receiver_idles) begin
        gap = $urandom_range(0, 3);
        rx_wait <= gap;
        out_ready <= (gap == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // fixed part of a reply: header up to and including the cookie
  task automatic put_header(logic [7:0] op, logic [31:0] xid, logic cookie_right);
    pkt.delete();
    repeat (OFS_OPTIONS) pkt.push_back(8'($urandom));
    pkt[OFS_OP] = op;
    for (int i = 0; i < 4; i++) pkt[OFS_XID_FIRST + i] = xid[8*(3 - i) +: 8];
    pkt[OFS_COOKIE0] = COOKIE_B0;
    pkt[OFS_COOKIE1] = COOKIE_B1;
    if (!cookie_right) begin
      if ($urandom_range(0, 1) != 0) pkt[OFS_COOKIE0] = COOKIE_B0 ^ 8'($urandom_range(1, 255));
      else pkt[OFS_COOKIE1] = COOKIE_B1 ^ 8'($urandom_range(1, 255));
    end
  endtask

  // one option: value bytes come from the top of value, then random
  task automatic add_opt(logic [7:0] code, logic [7:0] len, logic [31:0] value);
    pkt.push_back(code);
    pkt.push_back(len);
    for (int i = 0; i < len; i++) pkt.push_back(i < 4 ? value[8*(3 - i) +: 8] : 8'($urandom));
  endtask

  task automatic trim_to(int unsigned n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  // turn pkt into words; the port only matters on the last byte
  task automatic queue_packet(logic [15:0] port);
    byte_word_t w;
    foreach (pkt[i]) begin
      w.data = pkt[i];
      w.last = (i == pkt.size() - 1);
      w.port = w.last ? port : 16'($urandom);
      pending_words.push_back(w);
    end
  endtask

  // reply cut off inside the fixed header
  task automatic short_packet(int unsigned n);
    put_header(BOOTREPLY, xid_reg, 1'b1);
    add_opt(OPT_MSG_TYPE, 8'd1, 32'h0600_0000);
    trim_to(n);
    queue_packet(SERVER_PORT);
  endtask

  // let everything in flight come out
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_xid(logic [31:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    xid_reg = v;
    @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // good reply: pads, wrong-length first instances shadow good ones,
    // zero-length and long options, trailing junk after end
    put_header(BOOTREPLY, xid_reg, 1'b1);
    pkt.push_back(OPT_PAD);
    add_opt(OPT_MSG_TYPE, 8'd2, 32'h0303_0000);
    add_opt(OPT_MSG_TYPE, 8'd1, 32'h0500_0000);
    add_opt(OPT_SRV_IDENT, 8'd5, 32'h0A0B_0C0D);
    add_opt(OPT_SRV_IDENT, 8'd4, 32'hC0A8_0101);
    add_opt(OPT_MASK, 8'd4, 32'hFFFF_FF00);
    add_opt(8'd200, 8'd0, 32'h0);
    add_opt(OPT_ROUTER, 8'd8, 32'hC0A8_01FE);
    add_opt(OPT_DNS, 8'd4, 32'h0808_0808);
    pkt.push_back(OPT_PAD);
    pkt.push_back(OPT_END);
    repeat (3) pkt.push_back(8'($urandom));
    queue_packet(SERVER_PORT);
    drain();

    // short payloads around the address field, no idling
    set_xid($urandom);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    short_packet(1);
    short_packet(19);
    short_packet(20);
    drain();

    // receiver holds off while tiny packets pile up behind the output
    receiver_idles = 1'b1;
    hold_go = 1'b1;
    repeat (30) begin
      pkt.delete();
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
      queue_packet(($urandom_range(0, 1) != 0) ? SERVER_PORT : 16'($urandom));
    end
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== dhcp_reply_field_extractor.f =====
src/dhcp_rfe_pkg.sv
src/dhcp_rfe_parser.sv
src/dhcp_reply_field_extractor.sv
verif/dhcp_reply_field_extractor_test.sv
